// ===== design/timed_path_interpolator_assert.svh =====
// assertion macros used by the checker file
`ifndef TIMED_PATH_INTERPOLATOR_ASSERT_SVH
`define TIMED_PATH_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define TPI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tpi assertion failed");

// next-cycle implication
`define TPI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpi assertion failed");

`endif

// ===== design/tpi_pkg.sv =====
// types and constants of the timed path interpolator
package tpi_pkg;

  localparam int unsigned MaxPoints = 256;
  localparam int unsigned IdxW      = 8;
  localparam int unsigned CntW      = 9;
  localparam int unsigned NumW      = 57;
  localparam int unsigned PosW      = 25;
  localparam logic [15:0] LookbackReset = 16'd92;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_CLEAR  = 3'd1;
  localparam logic [2:0] OP_FINISH = 3'd2;
  localparam logic [2:0] OP_POS    = 3'd3;
  localparam logic [2:0] OP_VEL    = 3'd4;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0]        t;
  } entry_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

endpackage

// ===== design/tpi_in_if.sv =====
// request channel of the timed path interpolator
interface tpi_in_if import tpi_pkg::*;;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic [31:0]        now_ticks;
  logic [31:0]        query_time;

  modport source (output valid, operation, point_x, point_y, now_ticks, query_time,
                  input ready);
  modport sink (input valid, operation, point_x, point_y, now_ticks, query_time,
                output ready);
endinterface

// ===== design/tpi_out_if.sv =====
// result channel of the timed path interpolator
interface tpi_out_if import tpi_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] out_x;
  logic signed [PosW-1:0] out_y;
  logic [CntW-1:0]        point_count;
  logic [31:0]            duration;
  logic                   recording;
  logic                   dropped;

  modport source (output valid, out_x, out_y, point_count, duration, recording, dropped,
                  input ready);
  modport sink (input valid, out_x, out_y, point_count, duration, recording, dropped,
                output ready);
endinterface

// ===== design/timed_path_interpolator.sv =====
// timed path interpolator: point table, segment scan and serial divider
//
//  channel   dir  handshake        contents
//  in_i      in   valid/ready      operation, point, now_ticks, query_time
//  out_o     out  valid/ready      position or velocity, count, duration, flags
//  cfg       in   cfg_we_i         lookback_ticks
//
// add, clear and finish go straight to the result stage; a position query with
// a matching segment scans and interpolates, a velocity query twice (two table scans,
// one memory read port, one 57-step restoring divider shared by x and y).
// rst_ni clears the control state; the point table is not cleared.
// a new word is taken while a finished result still waits in the output register.
module timed_path_interpolator import tpi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tpi_in_if.sink      in_i,
  tpi_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  state_e state_q;

  logic [2:0]      op_q;
  logic [31:0]     t_q;
  logic            pass_q;
  logic [CntW-1:0] count_q;
  logic [31:0]     start_q;
  logic            rec_q;
  logic [31:0]     last_t_q;
  logic [15:0]     lb_q;
  logic            dropped_q;

  entry_t          mem_q [MaxPoints];
  entry_t          rd_q;
  logic            mem_we;
  entry_t          mem_wdata;

  logic [CntW-1:0] addr_q;
  logic            pend_q;
  logic [IdxW-1:0] pidx_q;
  entry_t          prev_q, h0_q, h1_q;
  logic            hit_q;

  logic            coord_q;
  logic [NumW-1:0] num_q;
  logic [31:0]     rem_q;
  logic [5:0]      step_q;
  logic signed [PosW-1:0] px_q, cur_x_q, cur_y_q, res_x_q, res_y_q;

  logic            out_valid_q;
  logic signed [PosW-1:0] out_x_q, out_y_q;
  logic [CntW-1:0] out_cnt_q;
  logic [31:0]     out_dur_q;
  logic            out_rec_q, out_drop_q;

  logic            in_acc;
  logic [31:0]     add_t;
  logic            add_restart;
  logic [31:0]     whole, part;
  logic signed [15:0] ca, cb;
  logic signed [16:0] diff;
  logic [16:0]     mag;
  logic [47:0]     prod;
  logic [32:0]     rem_sh, rem_sub;
  logic            ge;
  logic signed [PosW-1:0] base, qv, pos;
  logic [31:0]     earlier;
  logic            scan_done;
  logic            pass_end;
  logic signed [PosW-1:0] rx, ry;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign add_restart = !rec_q || (count_q == '0);
  assign add_t       = add_restart ? 32'd0 : in_i.now_ticks - start_q;
  assign mem_we      = in_acc && (in_i.operation == OP_ADD) && (count_q < CntW'(MaxPoints));
  assign mem_wdata   = '{x: in_i.point_x, y: in_i.point_y, t: add_t};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[IdxW-1:0]] <= mem_wdata;
    end
    rd_q <= mem_q[addr_q[IdxW-1:0]];
  end

  assign whole = h1_q.t - h0_q.t;
  assign part  = t_q - h0_q.t;
  assign ca    = coord_q ? h0_q.y : h0_q.x;
  assign cb    = coord_q ? h1_q.y : h1_q.x;
  assign diff  = 17'(cb) - 17'(ca);
  assign mag   = diff[16] ? 17'(-diff) : 17'(diff);
  assign prod  = mag[15:0] * part;

  // one restoring division step
  assign rem_sh  = {rem_q, num_q[NumW-1]};
  assign rem_sub = rem_sh - {1'b0, whole};
  assign ge      = (rem_sh >= {1'b0, whole});

  assign base = {ca[15], ca, 8'h00};
  assign qv   = {1'b0, num_q[23:0]};
  assign pos  = diff[16] ? base - qv : base + qv;

  assign earlier   = (t_q >= {16'h0000, lb_q}) ? t_q - {16'h0000, lb_q} : 32'd0;
  assign scan_done = rec_q || ((addr_q == count_q) && !pend_q);

  always_comb begin
    pass_end = 1'b0;
    rx = '0;
    ry = '0;
    if (state_q == S_SCAN && scan_done && !(hit_q && !rec_q)) begin
      pass_end = 1'b1;
    end else if (state_q == S_FIN && coord_q) begin
      pass_end = 1'b1;
      rx = px_q;
      ry = pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_ADD;
      t_q         <= '0;
      pass_q      <= 1'b0;
      count_q     <= '0;
      start_q     <= '0;
      rec_q       <= 1'b0;
      last_t_q    <= '0;
      lb_q        <= LookbackReset;
      dropped_q   <= 1'b0;
      addr_q      <= '0;
      pend_q      <= 1'b0;
      pidx_q      <= '0;
      prev_q      <= '0;
      h0_q        <= '0;
      h1_q        <= '0;
      hit_q       <= 1'b0;
      coord_q     <= 1'b0;
      num_q       <= '0;
      rem_q       <= '0;
      step_q      <= '0;
      px_q        <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      res_x_q     <= '0;
      res_y_q     <= '0;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_cnt_q   <= '0;
      out_dur_q   <= '0;
      out_rec_q   <= 1'b0;
      out_drop_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lb_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q      <= in_i.operation;
            t_q       <= in_i.query_time;
            pass_q    <= 1'b0;
            dropped_q <= 1'b0;
            res_x_q   <= '0;
            res_y_q   <= '0;
            addr_q    <= '0;
            pend_q    <= 1'b0;
            hit_q     <= 1'b0;
            state_q   <= S_DONE;
            case (in_i.operation) inside
              OP_ADD: begin
                if (count_q >= CntW'(MaxPoints)) begin
                  dropped_q <= 1'b1;
                end else begin
                  if (add_restart) begin
                    start_q <= in_i.now_ticks;
                    rec_q   <= 1'b1;
                  end
                  last_t_q <= add_t;
                  count_q  <= count_q + 1'b1;
                end
              end
              OP_CLEAR: begin
                count_q <= '0;
                rec_q   <= 1'b0;
              end
              OP_FINISH: rec_q <= 1'b0;
              OP_POS, OP_VEL: state_q <= S_SCAN;
              default: ;
            endcase
          end
        end

        S_SCAN: begin
          if (scan_done) begin
            pend_q <= 1'b0;
            if (hit_q && !rec_q) begin
              coord_q <= 1'b0;
              state_q <= S_MUL;
            end
          end else begin
            if (addr_q != count_q) begin
              addr_q <= addr_q + 1'b1;
              pend_q <= 1'b1;
              pidx_q <= addr_q[IdxW-1:0];
            end else begin
              pend_q <= 1'b0;
            end
            if (pend_q) begin
              // later segments win
              if (pidx_q != '0 && t_q >= prev_q.t && t_q <= rd_q.t) begin
                hit_q <= 1'b1;
                h0_q  <= prev_q;
                h1_q  <= rd_q;
              end
              prev_q <= rd_q;
            end
          end
        end

        S_MUL: begin
          rem_q  <= '0;
          step_q <= 6'(NumW - 1);
          if (whole == '0) begin
            num_q   <= '0;
            state_q <= S_FIN;
          end else begin
            num_q   <= {1'b0, prod, 8'h00} + NumW'(whole[31:1]);
            state_q <= S_DIV;
          end
        end

        S_DIV: begin
          rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
          num_q <= {num_q[NumW-2:0], ge};
          if (step_q == '0) begin
            state_q <= S_FIN;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end

        S_FIN: begin
          if (!coord_q) begin
            px_q    <= pos;
            coord_q <= 1'b1;
            state_q <= S_MUL;
          end
        end

        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_x_q     <= res_x_q;
            out_y_q     <= res_y_q;
            out_cnt_q   <= count_q;
            out_dur_q   <= (count_q != '0) ? last_t_q : 32'd0;
            out_rec_q   <= rec_q;
            out_drop_q  <= dropped_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase

      if (pass_end) begin
        if (!pass_q && op_q == OP_VEL) begin
          // second pass at the look-back time
          cur_x_q <= rx;
          cur_y_q <= ry;
          pass_q  <= 1'b1;
          t_q     <= earlier;
          addr_q  <= '0;
          pend_q  <= 1'b0;
          hit_q   <= 1'b0;
          state_q <= S_SCAN;
        end else begin
          res_x_q <= pass_q ? cur_x_q - rx : rx;
          res_y_q <= pass_q ? cur_y_q - ry : ry;
          state_q <= S_DONE;
        end
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_x       = out_x_q;
  assign out_o.out_y       = out_y_q;
  assign out_o.point_count = out_cnt_q;
  assign out_o.duration    = out_dur_q;
  assign out_o.recording   = out_rec_q;
  assign out_o.dropped     = out_drop_q;

endmodule

// ===== design/tpi_checker.sv =====
// port-level checks for the timed path interpolator, bound to the top level
`include "timed_path_interpolator_assert.svh"

module tpi_checker import tpi_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic [CntW-1:0] point_count_i,
  input logic            dropped_i,
  input logic            recording_i
);

  // a held word stays offered
  `TPI_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  // one word at a time
  `TPI_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i)
  `TPI_ASSERT_NOW(a_count_range, out_valid_i, point_count_i <= CntW'(MaxPoints))
  `TPI_ASSERT_NOW(a_drop_full, out_valid_i && dropped_i,
                  point_count_i == CntW'(MaxPoints))
  `TPI_ASSERT_NOW(a_rec_nonempty, out_valid_i && recording_i, point_count_i != '0)

endmodule

bind timed_path_interpolator tpi_checker u_tpi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .point_count_i (out_o.point_count),
  .dropped_i     (out_o.dropped),
  .recording_i   (out_o.recording)
);

// ===== sim/tb_top.sv =====
// testbench of the timed path interpolator: table-driven and random words checked in order
module tb_top import tpi_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int unsigned IdleLimit = 6000;
  localparam int unsigned HoldCycles = 500;
  localparam int unsigned NumItems = 1050;

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic [CntW-1:0]        cnt;
    logic [31:0]            dur;
    logic                   rec;
    logic                   drop;
  } path_res_t;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] px;
    logic [15:0] py;
    logic [31:0] now;
    logic [31:0] qt;
    bit          typed;
    path_res_t   res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  tpi_in_if  req_if ();
  tpi_out_if res_if ();

  timed_path_interpolator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (req_if),
    .out_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // predictor state
  entry_t      path_tbl [MaxPoints];
  int unsigned n_stored;
  logic [31:0] rec_start;
  bit          rec_on;
  logic [15:0] lookback;

  path_res_t   pending_res [$];
  row_t        directed_rows [$];
  int unsigned n_sent, n_checked, n_errors, n_drops, n_cfg, idle_cycles;
  bit          idle_en, hold_req;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint lerp_q8(input longint a, input longint b,
                                     input logic [31:0] part, input logic [31:0] whole);
    longint base, d;
    longint unsigned mag, q;
    base = a * 256;
    d = b - a;
    if (whole == 0) return base;
    mag = (d < 0) ? -d : d;
    q = (mag * part * 64'd256 + (whole >> 1)) / whole;
    return (d < 0) ? base - longint'(q) : base + longint'(q);
  endfunction

  function automatic void pos_at(input logic [31:0] t, output longint ox, output longint oy);
    ox = 0;
    oy = 0;
    if (rec_on || n_stored == 0) return;
    // later segments win when spans overlap
    for (int i = 0; i + 1 < n_stored; i++) begin
      if (t >= path_tbl[i].t && t <= path_tbl[i+1].t) begin
        ox = lerp_q8(path_tbl[i].x, path_tbl[i+1].x, t - path_tbl[i].t,
                     path_tbl[i+1].t - path_tbl[i].t);
        oy = lerp_q8(path_tbl[i].y, path_tbl[i+1].y, t - path_tbl[i].t,
                     path_tbl[i+1].t - path_tbl[i].t);
      end
    end
  endfunction

  function automatic path_res_t advance_path(input logic [2:0] op, input logic [15:0] px,
                                             input logic [15:0] py, input logic [31:0] now,
                                             input logic [31:0] qt);
    path_res_t r;
    longint cx, cy, ex, ey;
    logic [31:0] earlier;
    r = '0;
    case (op)
      OP_ADD: begin
        if (n_stored >= MaxPoints) begin
          r.drop = 1'b1;
        end else begin
          if (!rec_on || n_stored == 0) begin
            rec_start = now;
            rec_on = 1'b1;
          end
          path_tbl[n_stored] = '{x: px, y: py, t: now - rec_start};
          n_stored++;
        end
      end
      OP_CLEAR: begin
        n_stored = 0;
        rec_on = 1'b0;
      end
      OP_FINISH: rec_on = 1'b0;
      OP_POS: begin
        pos_at(qt, cx, cy);
        r.x = PosW'(cx);
        r.y = PosW'(cy);
      end
      OP_VEL: begin
        earlier = (qt >= lookback) ? qt - lookback : '0;
        pos_at(qt, cx, cy);
        pos_at(earlier, ex, ey);
        r.x = PosW'(cx - ex);
        r.y = PosW'(cy - ey);
      end
      default: ;
    endcase
    r.cnt = CntW'(n_stored);
    r.dur = (n_stored > 0) ? path_tbl[n_stored-1].t : '0;
    r.rec = rec_on;
    return r;
  endfunction

  function automatic path_res_t mk_res(input int x, input int y, input int cnt,
                                       input logic [31:0] dur, input bit rec);
    path_res_t r;
    r = '{x: PosW'(x), y: PosW'(y), cnt: CntW'(cnt), dur: dur, rec: rec, drop: 1'b0};
    return r;
  endfunction

  task automatic add_row(input logic [2:0] op, input int px, input int py,
                         input logic [31:0] now, input logic [31:0] qt,
                         input bit typed = 0, input path_res_t res = '0);
    row_t row;
    row = '{op: op, px: 16'(px), py: 16'(py), now: now, qt: qt, typed: typed, res: res};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // hold a word on the request channel until it is taken, then log its outcome
  task automatic send_word(input logic [2:0] op, input logic [15:0] px, input logic [15:0] py,
                           input logic [31:0] now, input logic [31:0] qt,
                           input bit typed = 0, input path_res_t res = '0);
    path_res_t pred;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.point_x    <= px;
    req_if.point_y    <= py;
    req_if.now_ticks  <= now;
    req_if.query_time <= qt;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pred = advance_path(op, px, py, now, qt);
    pending_res.insert(pending_res.size(), typed ? res : pred);
    if (pred.drop) n_drops++;
    n_sent++;
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_res.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_lookback(input logic [15:0] v);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lookback = v;
    n_cfg++;
  endtask

  function automatic logic [31:0] pick_time();
    logic [31:0] t;
    if (n_stored == 0 || $urandom_range(0, 9) == 0) return $urandom;
    t = path_tbl[$urandom_range(0, n_stored - 1)].t;
    case ($urandom_range(0, 3))
      0: return t;
      1: return t + $urandom_range(0, 300);
      2: return t - $urandom_range(0, 300);
      default: return $urandom_range(0, 2000);
    endcase
  endfunction

  task automatic run_session(input int sidx);
    int n_add, n_q;
    logic [31:0] now;
    logic [2:0] op;
    if ($urandom_range(0, 4) != 0)
      send_word(OP_CLEAR, 16'($urandom), 16'($urandom), $urandom, $urandom);
    n_add = (sidx == 3 || ($urandom_range(0, 39) == 0 && n_sent + 300 < NumItems))
            ? $urandom_range(256, 262) : $urandom_range(1, 8);
    now = $urandom;
    for (int i = 0; i < n_add; i++) begin
      send_word(OP_ADD, 16'($urandom), 16'($urandom), now, $urandom);
      case ($urandom_range(0, 9))
        0: now = now;
        1: now = now + $urandom;
        2: now = now - $urandom_range(1, 50);
        default: now = now + $urandom_range(1, 200);
      endcase
    end
    if ($urandom_range(0, 9) != 0)
      send_word(OP_FINISH, 16'($urandom), 16'($urandom), $urandom, $urandom);
    n_q = (n_add > 200) ? 3 : $urandom_range(3, 8);
    for (int i = 0; i < n_q; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        op = 3'($urandom_range(0, 7));
        send_word(op, 16'($urandom), 16'($urandom), $urandom, $urandom);
      end else begin
        op = $urandom_range(0, 1) ? OP_POS : OP_VEL;
        send_word(op, 16'($urandom), 16'($urandom), $urandom, pick_time());
      end
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall_cnt, hold_cnt;
    path_res_t want, got;
    stall_cnt = 0;
    hold_cnt = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        got = '{x: res_if.out_x, y: res_if.out_y, cnt: res_if.point_count,
                dur: res_if.duration, rec: res_if.recording, drop: res_if.dropped};
        if (pending_res.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result word %p", got);
        end else begin
          want = pending_res.pop_front();
          n_checked++;
          if (got.x !== want.x || got.y !== want.y || got.cnt !== want.cnt ||
              got.dur !== want.dur || got.rec !== want.rec || got.drop !== want.drop) begin
            n_errors++;
            if (n_errors <= 10) $display("mismatch on result %0d: expected %p actual %p",
                                         n_checked, want, got);
          end
        end
      end
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = HoldCycles;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        res_if.ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        res_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall_cnt = $urandom_range(0, 2);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no traffic for %0d cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] lb_vals [4];
    int sidx;
    n_stored = 0;
    rec_start = '0;
    rec_on = 1'b0;
    lookback = LookbackReset;
    n_sent = 0;
    n_checked = 0;
    n_errors = 0;
    n_drops = 0;
    n_cfg = 0;
    idle_cycles = 0;
    idle_en = 1;
    hold_req = 0;
    foreach (path_tbl[i]) path_tbl[i] = '0;
    req_if.valid      <= 1'b0;
    req_if.operation  <= OP_CLEAR;
    req_if.point_x    <= '0;
    req_if.point_y    <= '0;
    req_if.now_ticks  <= '0;
    req_if.query_time <= '0;

    // directed rows: extremes, wrapped time stamps, every operation, corner cases
    add_row(OP_POS, 0, 0, 0, 0, 1, mk_res(0, 0, 0, 0, 0));
    add_row(OP_ADD, 32767, -32768, 32'hFFFF_FFFF, 0, 1, mk_res(0, 0, 1, 0, 1));
    add_row(OP_ADD, -32768, 32767, 32'd9, 0, 1, mk_res(0, 0, 2, 10, 1));
    add_row(OP_POS, 0, 0, 0, 5, 1, mk_res(0, 0, 2, 10, 1));
    add_row(OP_FINISH, 0, 0, 0, 0, 1, mk_res(0, 0, 2, 10, 0));
    add_row(OP_POS, 0, 0, 0, 5);
    add_row(OP_POS, 0, 0, 0, 0, 1, mk_res(8388352, -8388608, 2, 10, 0));
    add_row(OP_POS, 0, 0, 0, 10, 1, mk_res(-8388608, 8388352, 2, 10, 0));
    add_row(OP_POS, 0, 0, 0, 11, 1, mk_res(0, 0, 2, 10, 0));
    add_row(OP_POS, 0, 0, 0, 32'hFFFF_FFFF, 1, mk_res(0, 0, 2, 10, 0));
    add_row(OP_VEL, 0, 0, 0, 10);
    add_row(OP_VEL, 0, 0, 0, 3);
    add_row(OP_SPARE_LO, -1, -1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, mk_res(0, 0, 2, 10, 0));
    add_row(OP_SPARE_HI, 0, 0, 0, 0, 1, mk_res(0, 0, 2, 10, 0));
    add_row(OP_ADD, 0, 0, 100, 0);
    add_row(OP_FINISH, 0, 0, 0, 0);
    add_row(OP_POS, 0, 0, 0, 0);
    add_row(OP_CLEAR, 0, 0, 0, 0, 1, mk_res(0, 0, 0, 0, 0));
    add_row(OP_ADD, 5, -5, 500, 0);
    add_row(OP_ADD, 9, 7, 500, 0);
    add_row(OP_FINISH, 0, 0, 0, 0);
    // zero-length segment falls back to its first point
    add_row(OP_POS, 0, 0, 0, 0, 1, mk_res(1280, -1280, 2, 0, 0));
    add_row(OP_CLEAR, 0, 0, 0, 0, 1, mk_res(0, 0, 0, 0, 0));
    add_row(OP_ADD, 1, 1, 0, 0);
    add_row(OP_FINISH, 0, 0, 0, 0);
    add_row(OP_POS, 0, 0, 0, 0, 1, mk_res(0, 0, 1, 0, 0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].px, directed_rows[i].py,
                directed_rows[i].now, directed_rows[i].qt, directed_rows[i].typed,
                directed_rows[i].res);
    drain();

    lb_vals = '{16'd0, 16'hFFFF, 16'd1, 16'd92};
    sidx = 0;
    while (n_sent < NumItems) begin
      if (sidx % 8 == 0)
        set_lookback((sidx % 40 == 16) ? 16'($urandom) : lb_vals[(sidx / 8) % 4]);
      if (sidx == 10) hold_req = 1;
      if (n_sent > 900) idle_en = 0;
      run_session(sidx);
      sidx++;
    end
    req_if.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    if (pending_res.size() != 0) n_errors++;
    $display("%0d words sent, %0d results checked, %0d full-table drops, %0d lookback writes",
             n_sent, n_checked, n_drops, n_cfg);
    $display("%0d mismatches", n_errors);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/tpi_pkg.sv
design/tpi_in_if.sv
design/tpi_out_if.sv
design/timed_path_interpolator.sv
design/tpi_checker.sv
sim/tb_top.sv
